// ===== hdl/dersig_pkg.sv =====
// ============================================================================
// dersig_pkg
// Types, constants and helper functions for the strict DER signature checker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dersig_pkg;

    // Running comparison of a big-endian integer against a constant
    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    typedef enum logic [2:0] {
        PH_SEQ_TAG = 3'd0,
        PH_SEQ_LEN = 3'd1,
        PH_R_TAG   = 3'd2,
        PH_R_LEN   = 3'd3,
        PH_R_VAL   = 3'd4,
        PH_S_TAG   = 3'd5,
        PH_S_LEN   = 3'd6,
        PH_S_VAL   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_INVALID = 2'd0,
        STATUS_HIGH_S  = 2'd1,
        STATUS_LOW_S   = 2'd2
    } status_t;

    localparam logic [7:0] SEQ_TAG      = 8'h30;
    localparam logic [7:0] INT_TAG      = 8'h02;
    localparam logic [7:0] MAX_PART_LEN = 8'd33;
    localparam logic [6:0] MIN_SIG_LEN  = 7'd8;
    localparam logic [6:0] MAX_SIG_LEN  = 7'd72;
    localparam logic [6:0] COUNT_MAX    = 7'd127;
    localparam logic [5:0] LAST_POS     = 6'd33;

    // secp256k1 group order, left-padded to 33 bytes, and floor(n/2)
    localparam logic [263:0] ORDER_N =
        264'h00_FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
    localparam logic [263:0] HALF_N = ORDER_N >> 1;

    // Byte of a 33-byte constant at big-endian position pos (0..32)
    function automatic logic [7:0] const_byte(input logic [263:0] value,
                                              input logic [5:0] pos);
        logic [7:0] result;
        result = 8'h00;
        for (int i = 0; i < 33; i++) begin
            if (pos == 6'(i)) begin
                result = value[8*(32-i) +: 8];
            end
        end
        return result;
    endfunction

    function automatic cmp_t cmp_step(input cmp_t st, input logic [7:0] b,
                                      input logic [7:0] t);
        cmp_t result;
        if (st != CMP_EQ) begin
            result = st;
        end
        else if (b < t) begin
            result = CMP_LT;
        end
        else if (b > t) begin
            result = CMP_GT;
        end
        else begin
            result = CMP_EQ;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/der_ecdsa_signature_canonicality.sv =====
// ============================================================================
// der_ecdsa_signature_canonicality
// Byte-serial strict DER check of a secp256k1 ECDSA signature with low-S
// classification.
// ============================================================================
// One signature byte is taken per request and per cycle; the parse and the
// running compares against the group order and its half are updated in the
// cycle the byte is accepted. On the byte marked last, a status is loaded
// into the result register at the accepting edge and offered from the next
// cycle (0 invalid, 1 canonical with high S, 2 fully canonical), and the
// parse state returns to its start. Bytes that are not last are taken even
// while a result waits; a last byte waits only if the result register is
// full and not being drained that cycle.
`timescale 1ns / 1ps
`default_nettype none

module der_ecdsa_signature_canonicality
    import dersig_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] sig_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status
);

    logic [6:0] byte_count_reg,      byte_count_next;
    logic [7:0] declared_length_reg, declared_length_next;
    phase_t     phase_reg,           phase_next;
    logic [5:0] part_length_reg,     part_length_next;
    logic [5:0] part_remaining_reg,  part_remaining_next;
    logic       lead_zero_reg,       lead_zero_next;
    logic       error_reg,           error_next;
    cmp_t       r_order_reg,         r_order_next;
    cmp_t       s_order_reg,         s_order_next;
    cmp_t       s_half_reg,          s_half_next;
    logic       out_valid_reg;
    status_t    status_reg,          status_next;

    logic       in_fire;
    logic       first_value;
    logic       second_value;
    logic [5:0] pos;
    logic [7:0] count_minus_two;
    logic       sig_ok;

    assign in_ready  = !out_valid_reg || out_ready || !last;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    assign first_value  = (part_remaining_reg == part_length_reg);
    assign second_value = (part_remaining_reg == part_length_reg - 6'd1);
    assign pos          = LAST_POS - part_remaining_reg;

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        phase_next           = phase_reg;
        part_length_next     = part_length_reg;
        part_remaining_next  = part_remaining_reg;
        lead_zero_next       = lead_zero_reg;
        error_next           = error_reg;
        r_order_next         = r_order_reg;
        s_order_next         = s_order_reg;
        s_half_next          = s_half_reg;
        status_next          = STATUS_INVALID;
        count_minus_two      = 8'd0;
        sig_ok               = 1'b0;

        if (byte_count_reg < COUNT_MAX) begin
            byte_count_next = byte_count_reg + 7'd1;
        end

        if (!error_reg) begin
            unique case (phase_reg)
                PH_SEQ_TAG:
                begin
                    if (sig_byte != SEQ_TAG) error_next = 1'b1;
                    else                     phase_next = PH_SEQ_LEN;
                end
                PH_SEQ_LEN:
                begin
                    declared_length_next = sig_byte;
                    phase_next           = PH_R_TAG;
                end
                PH_R_TAG, PH_S_TAG:
                begin
                    if (sig_byte != INT_TAG) error_next = 1'b1;
                    else phase_next = (phase_reg == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                end
                PH_R_LEN, PH_S_LEN:
                begin
                    if (sig_byte == 8'd0 || sig_byte > MAX_PART_LEN) begin
                        error_next = 1'b1;
                    end
                    else begin
                        part_length_next    = sig_byte[5:0];
                        part_remaining_next = sig_byte[5:0];
                        lead_zero_next      = 1'b0;
                        // short parts carry implicit leading zeros: below n
                        if (phase_reg == PH_R_LEN) begin
                            r_order_next = (sig_byte <= 8'd31) ? CMP_LT : CMP_EQ;
                            phase_next   = PH_R_VAL;
                        end
                        else begin
                            s_order_next = (sig_byte <= 8'd31) ? CMP_LT : CMP_EQ;
                            s_half_next  = (sig_byte <= 8'd31) ? CMP_LT : CMP_EQ;
                            phase_next   = PH_S_VAL;
                        end
                    end
                end
                PH_R_VAL, PH_S_VAL:
                begin
                    priority if (part_remaining_reg == 6'd0 ||
                                 part_remaining_reg > MAX_PART_LEN[5:0]) begin
                        // trailing bytes after S
                        error_next = 1'b1;
                    end
                    else if (first_value && sig_byte[7]) begin
                        error_next = 1'b1;
                    end
                    else if (first_value && sig_byte == 8'd0 &&
                             part_length_reg == 6'd1) begin
                        error_next = 1'b1;
                    end
                    else if (!first_value && lead_zero_reg && second_value &&
                             !sig_byte[7]) begin
                        // padding byte not needed
                        error_next = 1'b1;
                    end
                    else begin
                        if (first_value && sig_byte == 8'd0) lead_zero_next = 1'b1;
                        if (phase_reg == PH_R_VAL) begin
                            r_order_next = cmp_step(r_order_reg, sig_byte,
                                                    const_byte(ORDER_N, pos));
                        end
                        else begin
                            s_order_next = cmp_step(s_order_reg, sig_byte,
                                                    const_byte(ORDER_N, pos));
                            s_half_next  = cmp_step(s_half_reg, sig_byte,
                                                    const_byte(HALF_N, pos));
                        end
                        part_remaining_next = part_remaining_reg - 6'd1;
                        if (phase_reg == PH_R_VAL && part_remaining_reg == 6'd1) begin
                            phase_next = PH_S_TAG;
                        end
                    end
                end
            endcase
        end

        if (last) begin
            count_minus_two = {1'b0, byte_count_next} - 8'd2;
            sig_ok = !error_next &&
                     byte_count_next >= MIN_SIG_LEN &&
                     byte_count_next <= MAX_SIG_LEN &&
                     declared_length_next == count_minus_two &&
                     phase_next == PH_S_VAL && part_remaining_next == 6'd0 &&
                     r_order_next == CMP_LT && s_order_next == CMP_LT;
            if (sig_ok) begin
                status_next = (s_half_next == CMP_GT) ? STATUS_HIGH_S : STATUS_LOW_S;
            end
            // drop all parse state for the next signature
            byte_count_next      = 7'd0;
            declared_length_next = 8'd0;
            phase_next           = PH_SEQ_TAG;
            part_length_next     = 6'd0;
            part_remaining_next  = 6'd0;
            lead_zero_next       = 1'b0;
            error_next           = 1'b0;
            r_order_next         = CMP_EQ;
            s_order_next         = CMP_EQ;
            s_half_next          = CMP_EQ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg      <= 7'd0;
            declared_length_reg <= 8'd0;
            phase_reg           <= PH_SEQ_TAG;
            part_length_reg     <= 6'd0;
            part_remaining_reg  <= 6'd0;
            lead_zero_reg       <= 1'b0;
            error_reg           <= 1'b0;
            r_order_reg         <= CMP_EQ;
            s_order_reg         <= CMP_EQ;
            s_half_reg          <= CMP_EQ;
            out_valid_reg       <= 1'b0;
        end
        else begin
            if (in_fire) begin
                byte_count_reg      <= byte_count_next;
                declared_length_reg <= declared_length_next;
                phase_reg           <= phase_next;
                part_length_reg     <= part_length_next;
                part_remaining_reg  <= part_remaining_next;
                lead_zero_reg       <= lead_zero_next;
                error_reg           <= error_next;
                r_order_reg         <= r_order_next;
                s_order_reg         <= s_order_next;
                s_half_reg          <= s_half_next;
            end
            if (in_fire && last) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last) begin
            status_reg <= status_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last) |=> (phase_reg == PH_SEQ_TAG && byte_count_reg == 7'd0
                               && !error_reg))
        else $error("parse state not cleared after last byte");

    a_remaining_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        part_remaining_reg <= part_length_reg)
        else $error("value bytes remaining exceed part length");

    a_pending_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && in_fire && !last) |=>
            (out_valid_reg && $stable(status_reg)))
        else $error("non-final byte disturbed a waiting result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == STATUS_INVALID ||
                           status_reg == STATUS_HIGH_S ||
                           status_reg == STATUS_LOW_S))
        else $error("undefined status code");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb
// Testbench for the strict DER secp256k1 signature checker. Feeds well-formed
// and broken DER signatures byte by byte under random idling and back
// pressure, and checks each status against a scoreboard that parses the
// same bytes.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import dersig_pkg::*;

    localparam logic [255:0] ORDER = ORDER_N[255:0];
    localparam logic [255:0] HALF  = HALF_N[255:0];

    typedef enum int {
        FAULT_NONE,
        FAULT_FLIP,
        FAULT_DECL_LEN,
        FAULT_TRUNC,
        FAULT_TRAIL,
        FAULT_PAD_R,
        FAULT_PAD_S,
        FAULT_NEG_S,
        FAULT_PART_LEN,
        FAULT_LONG,
        FAULT_NOISE,
        FAULT_SEQ_TAG,
        FAULT_INT_TAG
    } frame_fault_t;

    // Parses the accepted bytes and queues the status each signature should get
    class sig_status_scoreboard;
        logic [6:0] seen_count;
        logic [7:0] len_field;
        phase_t     phase;
        logic [5:0] int_len;
        logic [5:0] bytes_left;
        bit         zero_lead;
        bit         malformed;
        cmp_t       r_vs_n;
        cmp_t       s_vs_n;
        cmp_t       s_vs_half;
        status_t    status_q[$];
        int         mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            seen_count = '0;
            len_field  = '0;
            phase      = PH_SEQ_TAG;
            int_len    = '0;
            bytes_left = '0;
            zero_lead  = 1'b0;
            malformed  = 1'b0;
            r_vs_n     = CMP_EQ;
            s_vs_n     = CMP_EQ;
            s_vs_half  = CMP_EQ;
        endfunction

        static function cmp_t byte_order(logic [7:0] a, logic [7:0] b);
            if (a < b)
            begin
                return CMP_LT;
            end
            if (a > b)
            begin
                return CMP_GT;
            end
            return CMP_EQ;
        endfunction

        function void note_request(logic [7:0] b, logic is_last);
            cmp_t    init;
            bit      first;
            int      idx;
            status_t want;
            if (seen_count != COUNT_MAX)
            begin
                seen_count = seen_count + 7'd1;
            end
            // once malformed, bytes are only counted
            if (!malformed)
            begin
                case (phase)
                    PH_SEQ_TAG:
                    begin
                        if (b != SEQ_TAG)
                            malformed = 1'b1;
                        else
                            phase = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN:
                    begin
                        len_field = b;
                        phase = PH_R_TAG;
                    end
                    PH_R_TAG, PH_S_TAG:
                    begin
                        if (b != INT_TAG)
                            malformed = 1'b1;
                        else
                            phase = (phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
                    end
                    PH_R_LEN, PH_S_LEN:
                    begin
                        if (b == 8'd0 || b > MAX_PART_LEN)
                        begin
                            malformed = 1'b1;
                        end
                        else
                        begin
                            int_len    = b[5:0];
                            bytes_left = b[5:0];
                            zero_lead  = 1'b0;
                            // short integers sit below both bounds from the start
                            init = (b <= 8'd31) ? CMP_LT : CMP_EQ;
                            if (phase == PH_R_LEN)
                            begin
                                r_vs_n = init;
                                phase  = PH_R_VAL;
                            end
                            else
                            begin
                                s_vs_n    = init;
                                s_vs_half = init;
                                phase     = PH_S_VAL;
                            end
                        end
                    end
                    default:
                    begin
                        first = (bytes_left == int_len);
                        if (bytes_left == 6'd0)
                        begin
                            malformed = 1'b1;
                        end
                        else if (first && (b[7] || (b == 8'h00 && int_len == 6'd1)))
                        begin
                            malformed = 1'b1;
                        end
                        else if (!first && zero_lead && bytes_left == int_len - 6'd1 &&
                                 !b[7])
                        begin
                            malformed = 1'b1;
                        end
                        else
                        begin
                            if (first && b == 8'h00)
                            begin
                                zero_lead = 1'b1;
                            end
                            idx = 8 * (int'(bytes_left) - 1);
                            if (phase == PH_R_VAL)
                            begin
                                if (r_vs_n == CMP_EQ)
                                    r_vs_n = byte_order(b, ORDER_N[idx +: 8]);
                            end
                            else
                            begin
                                if (s_vs_n == CMP_EQ)
                                    s_vs_n = byte_order(b, ORDER_N[idx +: 8]);
                                if (s_vs_half == CMP_EQ)
                                    s_vs_half = byte_order(b, HALF_N[idx +: 8]);
                            end
                            bytes_left = bytes_left - 6'd1;
                            if (phase == PH_R_VAL && bytes_left == 6'd0)
                            begin
                                phase = PH_S_TAG;
                            end
                        end
                    end
                endcase
            end
            if (is_last)
            begin
                want = STATUS_INVALID;
                if (!malformed && seen_count >= MIN_SIG_LEN && seen_count <= MAX_SIG_LEN &&
                    int'(len_field) == int'(seen_count) - 2 && phase == PH_S_VAL &&
                    bytes_left == 6'd0 && r_vs_n == CMP_LT && s_vs_n == CMP_LT)
                begin
                    want = (s_vs_half == CMP_GT) ? STATUS_HIGH_S : STATUS_LOW_S;
                end
                status_q.push_back(want);
                clear();
            end
        endfunction

        function void check_status(logic [1:0] got);
            status_t want;
            if (status_q.size() == 0)
            begin
                $error("status: expected nothing, got %0d", got);
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    $error("status: expected %0d, got %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] sig_byte = 8'h00;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;

    sig_status_scoreboard sb;
    logic [7:0] frame[$];
    bit         send_gaps = 1'b1;
    bit         recv_gaps = 1'b1;
    int         recv_hold = 0;
    int         bytes_sent = 0;
    int         frames_sent = 0;

    der_ecdsa_signature_canonicality u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sig_byte  (sig_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_status(status);
            if (in_valid && in_ready)
                sb.note_request(sig_byte, last);
        end
    end

    // Result side: random stalls, plus a counted hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                out_ready = 1'b0;
                recv_hold--;
            end
            else
            begin
                out_ready = !(recv_gaps && $urandom_range(0, 99) < 14);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL der_ecdsa_signature_canonicality");
        $finish;
    end

    // Append DER INTEGER; pad adds a redundant zero, neg makes it read negative
    function automatic void push_int(input logic [255:0] v, input bit pad, input bit neg);
        int         lead;
        bit         wide;
        logic [7:0] b;
        lead = 0;
        while (lead < 31 && v[8*(31-lead) +: 8] == 8'h00)
            lead++;
        wide = v[8*(31-lead) + 7];
        frame.push_back(INT_TAG);
        frame.push_back(8'(32 - lead + int'(wide && !neg) + int'(pad)));
        if (pad)
            frame.push_back(8'h00);
        if (wide && !neg)
            frame.push_back(8'h00);
        for (int i = lead; i < 32; i++)
        begin
            b = v[8*(31-i) +: 8];
            if (i == lead && neg && !wide)
                b[7] = 1'b1;
            frame.push_back(b);
        end
    endfunction

    function automatic void build_frame(input logic [255:0] r, input logic [255:0] s,
                                        input frame_fault_t fault);
        int keep;
        int idx;
        frame.delete();
        frame.push_back(SEQ_TAG);
        frame.push_back(8'h00);
        push_int(r, fault == FAULT_PAD_R, 1'b0);
        push_int(s, fault == FAULT_PAD_S, fault == FAULT_NEG_S);
        frame[1] = 8'(frame.size() - 2);
        case (fault)
            FAULT_FLIP:
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom());
            FAULT_DECL_LEN:
                frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
            FAULT_TRUNC:
            begin
                keep = $urandom_range(1, frame.size() - 1);
                while (frame.size() > keep)
                    void'(frame.pop_back());
                if (keep >= 2 && $urandom_range(0, 1))
                    frame[1] = 8'(keep - 2);
            end
            FAULT_TRAIL, FAULT_LONG:
            begin
                repeat ((fault == FAULT_TRAIL) ? $urandom_range(1, 4) : $urandom_range(1, 90))
                    frame.push_back(8'($urandom()));
                if ($urandom_range(0, 1))
                    frame[1] = 8'(frame.size() - 2);
            end
            FAULT_PART_LEN:
            begin
                idx = $urandom_range(0, 1) ? 3 : 5 + int'(frame[3]);
                frame[idx] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(34, 255));
            end
            FAULT_NOISE:
            begin
                frame.delete();
                repeat ($urandom_range(1, 12))
                    frame.push_back(8'($urandom()));
            end
            FAULT_SEQ_TAG:
                frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
            FAULT_INT_TAG:
            begin
                idx = $urandom_range(0, 1) ? 2 : 4 + int'(frame[3]);
                frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic [255:0] pick_value();
        logic [255:0] v;
        int           k;
        v = '0;
        for (k = 0; k < 8; k++)
            v = {v[223:0], $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2:
                ;
            3:
                v = v >> (8 * $urandom_range(1, 31));
            4:
                v = ORDER + 256'($urandom_range(0, 4)) - 256'd2;
            5:
                v = HALF + 256'($urandom_range(0, 4)) - 256'd2;
            6, 7:
            begin
                k = $urandom_range(0, 31);
                v = ($urandom_range(0, 1)) ? ORDER : HALF;
                v[8*k +: 8] = 8'($urandom());
            end
            8:
                v = 256'($urandom_range(0, 3));
            default:
                v = (256'd1 << $urandom_range(0, 255)) - 256'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        @(negedge clk);
        while (send_gaps && $urandom_range(0, 99) < 14)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sig_byte = value;
        last     = is_last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    task automatic send_sig(input logic [255:0] r, input logic [255:0] s,
                            input frame_fault_t fault);
        build_frame(r, s, fault);
        send_frame();
    endtask

    task automatic send_random_sig();
        frame_fault_t fault;
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) < 30)
            fault = frame_fault_t'($urandom_range(FAULT_FLIP, FAULT_INT_TAG));
        send_sig(pick_value(), pick_value(), fault);
    endtask

    // Hold off new requests until every queued status has come back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_sig(256'd1, 256'd1, FAULT_NONE);
        send_sig(ORDER - 256'd1, ORDER - 256'd1, FAULT_NONE);
        send_sig(ORDER - 256'd1, HALF, FAULT_NONE);
        send_sig(256'd1, HALF + 256'd1, FAULT_NONE);
        send_sig(HALF, HALF - 256'd1, FAULT_NONE);
        send_sig(ORDER, 256'd1, FAULT_NONE);
        send_sig(256'd1, ORDER, FAULT_NONE);
        send_sig(256'd1 << 255, 256'h7f, FAULT_NONE);
        send_sig(256'd0, 256'd1, FAULT_NONE);
        send_sig(256'd5, 256'd7, FAULT_PAD_R);
        send_sig(256'd5, 256'h80, FAULT_PAD_S);
        send_sig(256'd5, 256'd7, FAULT_NEG_S);
        send_sig(256'd9, ORDER - 256'd1, FAULT_NEG_S);
        send_sig(256'd3, 256'd4, FAULT_TRAIL);
        send_sig(256'd3, 256'd4, FAULT_TRUNC);
        send_sig(256'd3, 256'd4, FAULT_DECL_LEN);
        send_sig(256'd3, 256'd4, FAULT_PART_LEN);
        send_sig(256'd3, 256'd4, FAULT_SEQ_TAG);
        send_sig(256'd3, 256'd4, FAULT_INT_TAG);
        // long enough to saturate the byte counter
        build_frame(ORDER - 256'd1, ORDER - 256'd1, FAULT_NONE);
        repeat (60)
            frame.push_back(8'($urandom()));
        send_frame();
        frame.delete();
        frame.push_back(SEQ_TAG);
        send_frame();
        drain();

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        while (bytes_sent < 450)
            send_random_sig();
        send_gaps = 1'b1;
        recv_gaps = 1'b1;

        // stall the result side long enough to back up the input
        recv_hold = 300;
        while (bytes_sent < 900)
            send_random_sig();
        drain();

        while (bytes_sent < 1400 || frames_sent < 80)
            send_random_sig();
        drain();
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS der_ecdsa_signature_canonicality");
        else
            $display("FAIL der_ecdsa_signature_canonicality");
        $finish;
    end

endmodule
